// ===== hdl/gamepad_button_conditioner_defines.svh =====
// ----------------------------------------------------------------------------
// Gamepad button conditioner: assertion macros
// Shared property wrappers, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef GAMEPAD_BUTTON_CONDITIONER_DEFINES_SVH
`define GAMEPAD_BUTTON_CONDITIONER_DEFINES_SVH

// Condition that must hold at every edge out of reset.
`define GBC_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Same-cycle implication.
`define GBC_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define GBC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/gbc_pkg.sv =====
// ----------------------------------------------------------------------------
// gbc_pkg
// Types and constants shared by the gamepad button conditioner modules.
// ----------------------------------------------------------------------------
package gbc_pkg;

  localparam int BTN_W  = 16;
  localparam int AXIS_W = 16;
  localparam int CNT_W  = 8;

  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 48;

  // Input request kinds (tuser)
  localparam logic OP_FRAME = 1'b0;
  localparam logic OP_LOAD  = 1'b1;

  // Configuration register indexes
  localparam logic CFG_REPEAT_ENABLE = 1'b0;
  localparam logic CFG_FRAME_STEP    = 1'b1;

  localparam logic signed [AXIS_W-1:0] STICK_NEG_LIMIT = -16'sh0800;
  localparam logic signed [AXIS_W-1:0] STICK_POS_LIMIT = 16'sh0801;

  localparam logic [BTN_W-1:0] DIR_LEFT  = 16'h8000;
  localparam logic [BTN_W-1:0] DIR_RIGHT = 16'h2000;
  localparam logic [BTN_W-1:0] DIR_UP    = 16'h1000;
  localparam logic [BTN_W-1:0] DIR_DOWN  = 16'h4000;
  localparam logic [BTN_W-1:0] DIR_GROUP = 16'hF000;

  localparam logic [CNT_W-1:0] REPEAT_FIRE   = 8'd30;
  localparam logic [CNT_W-1:0] REPEAT_RELOAD = 8'd22;
  localparam logic [CNT_W-1:0] CNT_MAX       = 8'hFF;

  typedef struct packed {
    logic                     op;
    logic [BTN_W-1:0]         raw_buttons;
    logic                     analog_mode;
    logic signed [AXIS_W-1:0] stick_x;
    logic signed [AXIS_W-1:0] stick_y;
    logic [CNT_W-1:0]         cooldown_value;
  } gbc_item_t;

  typedef struct packed {
    logic [BTN_W-1:0] held;
    logic [BTN_W-1:0] pressed;
    logic [BTN_W-1:0] released;
  } gbc_result_t;

  typedef struct packed {
    logic [BTN_W-1:0] held_buttons;
    logic [CNT_W-1:0] repeat_count;
    logic [CNT_W-1:0] cooldown_count;
  } gbc_state_t;

  typedef struct packed {
    logic             repeat_enable;
    logic [CNT_W-1:0] frame_step;
  } gbc_cfg_t;

endpackage

// ===== hdl/gbc_frame.sv =====
// ----------------------------------------------------------------------------
// gbc_frame
// Per-request logic: stick mapping, edge masks, auto-repeat and cooldown.
// ----------------------------------------------------------------------------
module gbc_frame (
  input  gbc_pkg::gbc_item_t   item,
  input  gbc_pkg::gbc_state_t  state,
  input  gbc_pkg::gbc_cfg_t    cfg,
  output gbc_pkg::gbc_state_t  state_next,
  output gbc_pkg::gbc_result_t result,
  output logic                 has_result
);
  import gbc_pkg::*;

  logic [BTN_W-1:0] raw_inv;
  logic [BTN_W-1:0] cur;
  logic [BTN_W-1:0] prev;
  logic [BTN_W-1:0] pressed;
  logic [CNT_W:0]   sum;
  logic [CNT_W-1:0] sum_sat;
  logic [CNT_W-1:0] rc;
  logic [CNT_W-1:0] cd_dec;

  assign raw_inv = ~item.raw_buttons;
  assign prev    = state.held_buttons;
  assign sum     = {1'b0, state.repeat_count} + {1'b0, cfg.frame_step};
  assign sum_sat = sum[CNT_W] ? CNT_MAX : sum[CNT_W-1:0];
  assign cd_dec  = state.cooldown_count - 8'd1;

  always_comb begin
    cur = raw_inv;
    if (item.analog_mode) begin
      if (item.stick_x <  STICK_NEG_LIMIT) cur = cur | DIR_LEFT;
      if (item.stick_x >= STICK_POS_LIMIT) cur = cur | DIR_RIGHT;
      if (item.stick_y <  STICK_NEG_LIMIT) cur = cur | DIR_UP;
      if (item.stick_y >= STICK_POS_LIMIT) cur = cur | DIR_DOWN;
    end
  end

  always_comb begin
    state_next = state;
    result     = '0;
    has_result = 1'b0;
    pressed    = cur & ~prev;
    rc         = state.repeat_count;

    if (item.op == OP_LOAD) begin
      state_next.cooldown_count = item.cooldown_value;
    end else if (state.cooldown_count != '0) begin
      // suppressed frame; latch raw buttons only on the last one
      has_result                = 1'b1;
      state_next.cooldown_count = cd_dec;
      state_next.held_buttons   = (cd_dec == '0) ? raw_inv : '0;
      result.held               = state_next.held_buttons;
    end else begin
      has_result = 1'b1;
      if (cfg.repeat_enable) begin
        rc = ((prev & DIR_GROUP) == (cur & DIR_GROUP)) ? sum_sat : '0;
        if (rc >= REPEAT_FIRE) begin
          rc      = REPEAT_RELOAD;
          pressed = pressed | (cur & DIR_GROUP);
        end
      end
      state_next.held_buttons = cur;
      state_next.repeat_count = rc;
      result.held             = cur;
      result.pressed          = pressed;
      result.released         = prev & ~cur;
    end
  end

endmodule

// ===== hdl/gbc_out_stage.sv =====
// ----------------------------------------------------------------------------
// gbc_out_stage
// Result register on the master side; holds a result until it is taken.
// ----------------------------------------------------------------------------
module gbc_out_stage (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  gbc_pkg::gbc_result_t load_data,
  output logic                 free,
  output logic                 tvalid,
  input  logic                 tready,
  output gbc_pkg::gbc_result_t data
);
  import gbc_pkg::*;

  assign free = !tvalid || tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      tvalid <= 1'b0;
    end else if (load) begin
      tvalid <= 1'b1;
    end else if (tready) begin
      tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= load_data;
    end
  end

endmodule

// ===== hdl/gamepad_button_conditioner.sv =====
// ----------------------------------------------------------------------------
// gamepad_button_conditioner
// Per-frame gamepad conditioning: held / pressed / released masks with
// stick-to-dpad mapping, direction auto-repeat and a post-load cooldown.
//
//   channel  dir  payload
//   s_axis   in   frame sample or cooldown load (tuser selects)
//   m_axis   out  held, pressed, released
//   cfg      in   repeat_enable (index 0), frame_step (index 1)
//
// One request per cycle sustained while m_axis is not stalled. A request is
// registered, then processed combinationally against the state registers; a frame sample writes the
// result register, a load writes only the cooldown count (no result).
// A frame's result passes through the input register, then the result register.
// A stalled m_axis holds the result and backs up through the input register.
// Synchronous reset clears state, repeat_enable and both valid flags.
// ----------------------------------------------------------------------------
`include "gamepad_button_conditioner_defines.svh"

module gamepad_button_conditioner (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // raw_buttons[15:0], analog_mode[16], stick_x[32:17], stick_y[48:33],
  // cooldown_value[56:49], zero fill [63:57]
  input  logic [63:0] s_axis_tdata,
  // op[0]
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // held[15:0], pressed[31:16], released[47:32]
  output logic [47:0] m_axis_tdata,
  input  logic        cfg_wr_en,
  input  logic        cfg_addr,
  input  logic [7:0]  cfg_wdata
);
  import gbc_pkg::*;

  gbc_cfg_t    cfg;
  gbc_state_t  state;
  gbc_state_t  state_next;
  gbc_item_t   in_item;
  logic        in_valid;
  gbc_result_t result;
  gbc_result_t out_data;
  logic        has_result;
  logic        out_free;
  logic        advance;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.repeat_enable <= 1'b0;
      cfg.frame_step    <= 8'd1;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        CFG_REPEAT_ENABLE: cfg.repeat_enable <= cfg_wdata[0];
        CFG_FRAME_STEP:    cfg.frame_step    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // loads make no result, so they never wait on the output side
  assign advance       = in_valid && (!has_result || out_free);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item.op             <= s_axis_tuser;
      in_item.raw_buttons    <= s_axis_tdata[15:0];
      in_item.analog_mode    <= s_axis_tdata[16];
      in_item.stick_x        <= s_axis_tdata[32:17];
      in_item.stick_y        <= s_axis_tdata[48:33];
      in_item.cooldown_value <= s_axis_tdata[56:49];
    end
  end

  gbc_frame u_frame (
    .item       (in_item),
    .state      (state),
    .cfg        (cfg),
    .state_next (state_next),
    .result     (result),
    .has_result (has_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  gbc_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (advance && has_result),
    .load_data (result),
    .free      (out_free),
    .tvalid    (m_axis_tvalid),
    .tready    (m_axis_tready),
    .data      (out_data)
  );

  assign m_axis_tdata = {out_data.released, out_data.pressed, out_data.held};

  // every update of the repeat counter ends below the fire threshold
  `GBC_ASSERT_ALWAYS(a_repeat_below_fire, state.repeat_count < REPEAT_FIRE,
                     "repeat counter reached fire threshold")
  // suppressed frames report no edges
  `GBC_ASSERT_NEXT(a_cooldown_quiet,
                   advance && in_item.op == OP_FRAME && state.cooldown_count != '0,
                   out_data.pressed == '0 && out_data.released == '0,
                   "edge reported during cooldown")
  // a load request leaves held buttons and repeat counter alone
  `GBC_ASSERT_NEXT(a_load_keeps_state, advance && in_item.op == OP_LOAD,
                   $stable(state.held_buttons) && $stable(state.repeat_count),
                   "load request changed button state")
  // input stage only stalls when a pending result blocks it
  `GBC_ASSERT_IMPLY(a_stall_cause, !s_axis_tready,
                    in_valid && has_result && m_axis_tvalid && !m_axis_tready,
                    "input stalled without output back-pressure")

endmodule

// ===== dv/gbc_scoreboard_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbc_scoreboard_pkg
// Button-mask predictor and result checker for the gamepad conditioner bench.
// ----------------------------------------------------------------------------
package gbc_scoreboard_pkg;

  import gbc_pkg::*;

  class button_scoreboard;

    // predictor copy of block state and registers
    logic             rep_en;
    logic [CNT_W-1:0] step;
    logic [BTN_W-1:0] held_q;
    logic [CNT_W-1:0] rep_cnt;
    logic [CNT_W-1:0] cool_cnt;

    gbc_result_t expected_masks[$];
    int          errors;

    function new();
      rep_en   = 1'b0;
      step     = 8'd1;
      held_q   = '0;
      rep_cnt  = '0;
      cool_cnt = '0;
      errors   = 0;
    endfunction

    function void configure(logic idx, logic [7:0] value);
      if (idx == CFG_REPEAT_ENABLE) rep_en = value[0];
      else                          step   = value;
    endfunction

    function int pending();
      return expected_masks.size();
    endfunction

    // Advances the predictor by one accepted request; frames queue a result.
    function void predict_masks(gbc_item_t it);
      logic [BTN_W-1:0] inv;
      logic [BTN_W-1:0] cur;
      logic [BTN_W-1:0] prev;
      logic [CNT_W:0]   sum;
      gbc_result_t      res;
      inv = ~it.raw_buttons;
      if (it.op == OP_LOAD) begin
        cool_cnt = it.cooldown_value;
        return;
      end
      if (cool_cnt != 0) begin
        // suppressed frame; raw word latched unmapped on the last one
        cool_cnt     = cool_cnt - 1'b1;
        held_q       = (cool_cnt == 0) ? inv : '0;
        res.held     = held_q;
        res.pressed  = '0;
        res.released = '0;
        expected_masks.push_back(res);
        return;
      end
      cur = inv;
      if (it.analog_mode) begin
        if ($signed(it.stick_x) <  STICK_NEG_LIMIT) cur |= DIR_LEFT;
        if ($signed(it.stick_x) >= STICK_POS_LIMIT) cur |= DIR_RIGHT;
        if ($signed(it.stick_y) <  STICK_NEG_LIMIT) cur |= DIR_UP;
        if ($signed(it.stick_y) >= STICK_POS_LIMIT) cur |= DIR_DOWN;
      end
      prev         = held_q;
      res.held     = cur;
      res.pressed  = cur & (cur ^ prev);
      res.released = prev & (cur ^ prev);
      held_q       = cur;
      if (rep_en) begin
        if ((prev & DIR_GROUP) == (cur & DIR_GROUP)) begin
          sum     = {1'b0, rep_cnt} + {1'b0, step};
          rep_cnt = sum[CNT_W] ? CNT_MAX : sum[CNT_W-1:0];
        end else begin
          rep_cnt = '0;
        end
        if (rep_cnt >= REPEAT_FIRE) begin
          rep_cnt     = REPEAT_RELOAD;
          res.pressed = res.pressed | (cur & DIR_GROUP);
        end
      end
      expected_masks.push_back(res);
    endfunction

    function void note_request(gbc_item_t it);
      predict_masks(it);
    endfunction

    function void check_result(gbc_result_t act);
      gbc_result_t exp_r;
      if (expected_masks.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected: held %h pressed %h released %h",
                 $time, act.held, act.pressed, act.released);
        return;
      end
      exp_r = expected_masks.pop_front();
      if (act.held != exp_r.held) begin
        errors++;
        $display("%0t: held mismatch: expected %h actual %h", $time, exp_r.held, act.held);
      end
      if (act.pressed != exp_r.pressed) begin
        errors++;
        $display("%0t: pressed mismatch: expected %h actual %h",
                 $time, exp_r.pressed, act.pressed);
      end
      if (act.released != exp_r.released) begin
        errors++;
        $display("%0t: released mismatch: expected %h actual %h",
                 $time, exp_r.released, act.released);
      end
    endfunction

  endclass

endpackage

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Streams frame and cooldown requests into the gamepad conditioner under
// several register settings and idle patterns; every result is checked
// against a cycle-free predictor held in the scoreboard.
// ----------------------------------------------------------------------------
module tb_top;

  import gbc_pkg::*;
  import gbc_scoreboard_pkg::*;

  localparam int LIMIT_CYCLES = 500000;
  localparam int SETTLE       = 8;
  localparam int HOLD_LEN     = 300;
  localparam int PHASE_ITEMS  = 200;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;
  logic        s_tuser = OP_FRAME;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;
  logic        cfg_wr_en = 1'b0;
  logic        cfg_addr = CFG_REPEAT_ENABLE;
  logic [7:0]  cfg_wdata = '0;

  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  int hold_ticket  = 0;
  int cycles       = 0;

  // held pattern for the well-formed part of the random stimulus
  logic [15:0]        hold_raw    = 16'hFFFF;
  logic               hold_analog = 1'b0;
  logic signed [15:0] hold_sx     = '0;
  logic signed [15:0] hold_sy     = '0;

  button_scoreboard sb = new();

  gamepad_button_conditioner i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // input monitor
  always @(posedge clk) begin
    gbc_item_t it;
    if (!rst && s_tvalid && s_tready) begin
      it.op             = s_tuser;
      it.raw_buttons    = s_tdata[15:0];
      it.analog_mode    = s_tdata[16];
      it.stick_x        = s_tdata[32:17];
      it.stick_y        = s_tdata[48:33];
      it.cooldown_value = s_tdata[56:49];
      sb.note_request(it);
    end
  end

  // output monitor
  always @(posedge clk) begin
    gbc_result_t act;
    if (!rst && m_tvalid && m_tready) begin
      act.held     = m_tdata[15:0];
      act.pressed  = m_tdata[31:16];
      act.released = m_tdata[47:32];
      sb.check_result(act);
    end
  end

  // receiver; a new hold ticket forces a long stall
  initial begin : rx_proc
    int served;
    served = 0;
    forever begin
      @(posedge clk);
      if (hold_ticket != served) begin
        served = hold_ticket;
        m_tready <= 1'b0;
        repeat (HOLD_LEN - 1) @(posedge clk);
      end else begin
        m_tready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  task automatic send_item(gbc_item_t it);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= it.op;
    s_tdata  <= {7'd0, it.cooldown_value, it.stick_y, it.stick_x, it.analog_mode,
                 it.raw_buttons};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic send_frame(logic [15:0] raw, logic analog, logic signed [15:0] sx,
                            logic signed [15:0] sy);
    gbc_item_t it;
    it.op             = OP_FRAME;
    it.raw_buttons    = raw;
    it.analog_mode    = analog;
    it.stick_x        = sx;
    it.stick_y        = sy;
    it.cooldown_value = 8'($urandom);
    send_item(it);
  endtask

  task automatic send_load(logic [7:0] count);
    gbc_item_t it;
    it.op             = OP_LOAD;
    it.raw_buttons    = 16'($urandom);
    it.analog_mode    = 1'($urandom);
    it.stick_x        = 16'($urandom);
    it.stick_y        = 16'($urandom);
    it.cooldown_value = count;
    send_item(it);
  endtask

  // drop valid, wait out every expected result plus the load latency
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [7:0] value);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.configure(idx, value);
    @(posedge clk);
  endtask

  function automatic logic signed [15:0] pick_axis();
    case ($urandom_range(7))
      0:       return -16'sh0801;
      1:       return -16'sh0800;
      2:       return 16'sh0800;
      3:       return 16'sh0801;
      4:       return 16'sh8000;
      5:       return 16'sh7FFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_random();
    gbc_item_t it;
    int        pick;
    pick              = $urandom_range(99);
    it.op             = OP_FRAME;
    it.raw_buttons    = 16'($urandom);
    it.analog_mode    = 1'($urandom);
    it.stick_x        = 16'($urandom);
    it.stick_y        = 16'($urandom);
    it.cooldown_value = 8'($urandom);
    if (pick < 6) begin
      it.op = OP_LOAD;
      // long cooldowns stay rare, they swallow many frames
      if ($urandom_range(29) != 0) it.cooldown_value = 8'($urandom_range(4));
    end else if (pick >= 16) begin
      if ($urandom_range(9) == 0) begin
        hold_raw    = 16'($urandom);
        hold_analog = 1'($urandom);
        hold_sx     = pick_axis();
        hold_sy     = pick_axis();
      end
      it.raw_buttons = hold_raw;
      // jitter on non-direction buttons keeps the repeat counter running
      if ($urandom_range(3) == 0) it.raw_buttons[4'($urandom_range(11))] ^= 1'b1;
      it.analog_mode = hold_analog;
      it.stick_x     = hold_sx;
      it.stick_y     = hold_sy;
    end
    send_item(it);
  endtask

  task automatic run_phase(logic rep, logic [7:0] fstep, int tx_pct, int rx_pct,
                           bit hold_off);
    write_reg(CFG_REPEAT_ENABLE, {7'd0, rep});
    write_reg(CFG_FRAME_STEP, fstep);
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    if (hold_off) hold_ticket = hold_ticket + 1;
    repeat (PHASE_ITEMS) send_random();
    drain();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: masks, stick thresholds, cooldown
    write_reg(CFG_REPEAT_ENABLE, 8'd0);
    write_reg(CFG_FRAME_STEP, 8'd1);
    send_frame(16'hFFFF, 1'b0, 16'sh0000, 16'sh0000);
    send_frame(16'h0000, 1'b0, 16'sh0000, 16'sh0000);
    send_frame(16'hFFFF, 1'b0, 16'sh0000, 16'sh0000);
    send_frame(16'h5A5A, 1'b1, -16'sh0801, 16'sh0801);
    send_frame(16'h5A5A, 1'b1, -16'sh0800, 16'sh0800);
    send_frame(16'hA5A5, 1'b1, 16'sh0801, -16'sh0801);
    send_frame(16'hFFFF, 1'b1, 16'sh8000, 16'sh7FFF);
    send_frame(16'hFFFF, 1'b0, 16'sh8000, 16'sh7FFF);
    send_load(8'd3);
    send_frame(16'h0F0F, 1'b1, 16'sh8000, 16'sh8000);
    send_frame(16'h0F0F, 1'b1, 16'sh8000, 16'sh8000);
    send_frame(16'h0F0F, 1'b1, 16'sh8000, 16'sh8000);
    send_frame(16'h0F0F, 1'b1, 16'sh8000, 16'sh8000);
    send_load(8'd0);
    send_frame(16'hF0F0, 1'b0, 16'sh0000, 16'sh0000);
    drain();

    // directed: auto-repeat firing and counter saturation
    write_reg(CFG_REPEAT_ENABLE, 8'd1);
    write_reg(CFG_FRAME_STEP, 8'd10);
    repeat (6) send_frame(~DIR_LEFT, 1'b1, 16'sh0000, 16'sh7FFF);
    drain();
    write_reg(CFG_FRAME_STEP, 8'd255);
    repeat (3) send_frame(~DIR_LEFT, 1'b1, 16'sh0000, 16'sh7FFF);
    drain();

    run_phase(1'b1, 8'd1,   0,  0,  1'b0);
    run_phase(1'b1, 8'd255, 84, 0,  1'b0);
    run_phase(1'b0, 8'd7,   0,  84, 1'b0);
    run_phase(1'b1, 8'd0,   10, 10, 1'b0);
    run_phase(1'b1, 8'($urandom_range(1, 40)), 0, 10, 1'b1);
    run_phase(1'b1, 8'd3,   84, 84, 1'b0);

    repeat (SETTLE) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
